// ===== src/btl_pkg.sv =====
package btl_pkg;

	localparam int REQ_BITS        = 4;
	localparam int OP_BITS         = 2;
	localparam int OUT_TICKET_BITS = 8;
	localparam int STATUS_BITS     = 2;

	// operation codes
	localparam logic [OP_BITS-1:0] OP_TAKE    = 2'd0;
	localparam logic [OP_BITS-1:0] OP_POLL    = 2'd1;
	localparam logic [OP_BITS-1:0] OP_RELEASE = 2'd2;
	localparam logic [OP_BITS-1:0] OP_UNUSED  = 2'd3;

	// status codes
	localparam logic [STATUS_BITS-1:0] ST_OK        = 2'd0;
	localparam logic [STATUS_BITS-1:0] ST_OVERFLOW  = 2'd1;
	localparam logic [STATUS_BITS-1:0] ST_NO_TICKET = 2'd2;

	typedef struct packed {
		logic [OP_BITS-1:0]  op;
		logic [REQ_BITS-1:0] requester;
	} btl_cmd_t;

	typedef struct packed {
		logic [OUT_TICKET_BITS-1:0] ticket_value;
		logic                       granted;
		logic [STATUS_BITS-1:0]     status;
	} btl_result_t;

	// controller -> datapath
	typedef struct packed {
		logic load;
		logic rd_step;
		logic commit;
	} btl_ctrl_t;

	// datapath -> controller
	typedef struct packed {
		logic direct;
		logic scan_last;
	} btl_stat_t;

endpackage

// ===== src/btl_ram.sv =====
module btl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== src/btl_datapath.sv =====
module btl_datapath #(
	parameter int NUM_REQUESTERS = 16,
	parameter int TICKET_BITS    = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  btl_pkg::btl_cmd_t   cmd,
	input  btl_pkg::btl_ctrl_t  ctl,
	output btl_pkg::btl_stat_t  st,
	output btl_pkg::btl_result_t result
);

	localparam int IdxW     = $clog2(NUM_REQUESTERS);
	localparam int WhoW     = (IdxW > btl_pkg::REQ_BITS) ? IdxW : btl_pkg::REQ_BITS;
	localparam int WideBits = (TICKET_BITS > btl_pkg::OUT_TICKET_BITS) ?
		TICKET_BITS : btl_pkg::OUT_TICKET_BITS;

	btl_pkg::btl_cmd_t    cmd_q;
	btl_pkg::btl_result_t result_q;
	btl_pkg::btl_result_t res_d;

	logic [NUM_REQUESTERS-1:0] valid_q;
	logic [IdxW-1:0]           cnt_q;
	logic                      rd_vld_s1;
	logic                      ent_vld_s1;
	logic [IdxW-1:0]           idx_s1;
	logic [TICKET_BITS-1:0]    rd_data;
	logic [TICKET_BITS-1:0]    val;

	logic [TICKET_BITS-1:0]    max_q;
	logic [TICKET_BITS-1:0]    mine_q;
	logic                      best_found_q;
	logic [TICKET_BITS-1:0]    best_t_q;
	logic [IdxW-1:0]           best_j_q;

	logic [WhoW-1:0]           who_wide;
	logic [IdxW-1:0]           who;
	logic                      in_range;
	logic                      new_in_range;
	logic                      overflow;
	logic [TICKET_BITS-1:0]    next_ticket;
	logic                      blocked;
	logic                      take_ok;
	logic                      ram_we;
	logic                      clr_vld;
	logic [TICKET_BITS-1:0]    tv;
	logic [WideBits-1:0]       tv_wide;

	// requester decode of the held item and of the one being offered
	assign who_wide     = WhoW'(cmd_q.requester);
	assign who          = who_wide[IdxW-1:0];
	assign in_range     = ({28'd0, cmd_q.requester} < 32'(NUM_REQUESTERS));
	assign new_in_range = ({28'd0, cmd.requester} < 32'(NUM_REQUESTERS));

	assign st.direct    = !new_in_range || (cmd.op == btl_pkg::OP_RELEASE);
	assign st.scan_last = (cnt_q == IdxW'(NUM_REQUESTERS - 1));

	btl_ram #(
		.WIDTH(TICKET_BITS),
		.DEPTH(NUM_REQUESTERS)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(who),
		.wdata(next_ticket),
		.raddr(cnt_q),
		.rdata(rd_data)
	);

	assign val = ent_vld_s1 ? rd_data : '0;

	// commit: decide result and table update from the scan totals
	assign overflow    = (max_q == {TICKET_BITS{1'b1}});
	assign next_ticket = max_q + TICKET_BITS'(1);
	assign blocked     = best_found_q &&
		((best_t_q < mine_q) || ((best_t_q == mine_q) && (best_j_q < who)));

	always_comb begin
		res_d   = '0;
		take_ok = 1'b0;
		clr_vld = 1'b0;
		tv      = '0;
		if (!in_range) begin
			if (cmd_q.op == btl_pkg::OP_POLL) begin
				res_d.status = btl_pkg::ST_NO_TICKET;
			end
		end else begin
			unique case (cmd_q.op)
				btl_pkg::OP_TAKE: begin
					if (overflow) begin
						res_d.status = btl_pkg::ST_OVERFLOW;
						tv           = mine_q;
					end else begin
						take_ok = 1'b1;
						tv      = next_ticket;
					end
				end
				btl_pkg::OP_POLL: begin
					tv = mine_q;
					if (mine_q == '0) begin
						res_d.status = btl_pkg::ST_NO_TICKET;
					end else begin
						res_d.granted = !blocked;
					end
				end
				btl_pkg::OP_RELEASE: begin
					clr_vld = 1'b1;
				end
				default: begin
					tv = mine_q;
				end
			endcase
		end
		tv_wide            = WideBits'(tv);
		res_d.ticket_value = tv_wide[btl_pkg::OUT_TICKET_BITS-1:0];
	end

	assign ram_we = ctl.commit && take_ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q      <= '0;
			cnt_q        <= '0;
			rd_vld_s1    <= 1'b0;
			ent_vld_s1   <= 1'b0;
			max_q        <= '0;
			mine_q       <= '0;
			best_found_q <= 1'b0;
			result_q     <= '0;
		end else begin
			rd_vld_s1 <= ctl.rd_step;
			if (ctl.rd_step) begin
				ent_vld_s1 <= valid_q[cnt_q];
				cnt_q      <= cnt_q + IdxW'(1);
			end
			if (ctl.load) begin
				cnt_q        <= '0;
				max_q        <= '0;
				mine_q       <= '0;
				best_found_q <= 1'b0;
			end else if (rd_vld_s1) begin
				if (val > max_q) begin
					max_q <= val;
				end
				if (idx_s1 == who) begin
					mine_q <= val;
				end else if ((val != '0) && (!best_found_q || (val < best_t_q))) begin
					best_found_q <= 1'b1;
				end
			end
			if (ctl.commit) begin
				result_q <= res_d;
				if (ram_we) begin
					valid_q[who] <= 1'b1;
				end
				if (clr_vld) begin
					valid_q[who] <= 1'b0;
				end
			end
		end
	end

	// payload side of the scan
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			cmd_q <= cmd;
		end
		if (ctl.rd_step) begin
			idx_s1 <= cnt_q;
		end
		if (!ctl.load && rd_vld_s1 && (idx_s1 != who) && (val != '0) &&
			(!best_found_q || (val < best_t_q))) begin
			best_t_q <= val;
			best_j_q <= idx_s1;
		end
	end

	assign result = result_q;

`ifndef SYNTHESIS
	a_grant_ok: assert property (@(posedge clk) disable iff (!arst_n)
		result_q.granted |-> (result_q.status == btl_pkg::ST_OK))
		else $error("grant reported with nonzero status");

	a_take_marks: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |=> valid_q[$past(who)])
		else $error("taken ticket not marked valid");
`endif

endmodule

// ===== src/btl_ctrl.sv =====
module btl_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  btl_pkg::btl_stat_t st,
	output btl_pkg::btl_ctrl_t ctl,
	output logic               busy,
	output logic               done
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_DRAIN,
		S_COMMIT
	} state_t;

	state_t state_q;
	logic   done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q <= st.direct ? S_COMMIT : S_SCAN;
					end
				end
				S_SCAN: begin
					if (st.scan_last) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					state_q <= S_COMMIT;
				end
				S_COMMIT: begin
					state_q <= S_IDLE;
					done_q  <= 1'b1;
				end
			endcase
		end
	end

	assign ctl.load    = (state_q == S_IDLE) && start;
	assign ctl.rd_step = (state_q == S_SCAN);
	assign ctl.commit  = (state_q == S_COMMIT);
	assign busy        = (state_q != S_IDLE);
	assign done        = done_q;

`ifndef SYNTHESIS
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while busy");

	a_busy_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start))
		else $error("busy without a start");
`endif

endmodule

// ===== src/bakery_ticket_lock_core.sv =====
// Bakery ticket lock: one ticket per requester, lowest (ticket, requester) wins.
// Command channel: drive cmd (op, requester) with start; the item is taken at
//   the rising edge where start is high and busy is low. busy stays high
//   until the block can take the next item.
// Result channel: done pulses for exactly one cycle with result (ticket_value,
//   granted, status) valid in that cycle. There is no backpressure; the
//   receiver must capture the item on the done cycle. result holds until the
//   next item completes.
// Timing: take, poll and the unused op scan every ticket once through the
//   table RAM read port, one entry per cycle, then drain and commit: done
//   rises after the commit state and the next item can be accepted at the
//   edge that ends the done cycle, so items never overlap. Release and
//   out-of-range requesters skip the scan and go from idle to commit.
// Reset: arst_n clears every ticket at once through per-entry valid bits, so
//   the block can take items as soon as reset is released.
module bakery_ticket_lock_core #(
	parameter int NUM_REQUESTERS = 16,
	parameter int TICKET_BITS    = 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  btl_pkg::btl_cmd_t    cmd,
	output logic                 busy,
	output logic                 done,
	output btl_pkg::btl_result_t result
);

	btl_pkg::btl_ctrl_t ctl;
	btl_pkg::btl_stat_t st;

	// sequencer: idle -> scan -> drain -> commit, or idle -> commit for direct items
	btl_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.st    (st),
		.ctl   (ctl),
		.busy  (busy),
		.done  (done)
	);

	// ticket table, scan totals and result register
	btl_datapath #(
		.NUM_REQUESTERS(NUM_REQUESTERS),
		.TICKET_BITS   (TICKET_BITS)
	) u_datapath (
		.clk   (clk),
		.arst_n(arst_n),
		.cmd   (cmd),
		.ctl   (ctl),
		.st    (st),
		.result(result)
	);

endmodule

// ===== test/bakery_ticket_lock_core_tb.sv =====
module bakery_ticket_lock_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NUM_REQ     = 16;
	localparam int TKT_BITS    = 8;
	localparam int CLK_PERIOD  = 20;
	localparam int ITEM_TARGET = 1750;
	// cycles without an accept or a done before the run is declared hung;
	// worst case is one full scan item plus a short random idle run
	localparam int STALL_LIMIT = 2000;
	localparam logic [TKT_BITS-1:0] TICKET_TOP = '1;

	// ticket table mirror plus the queue of results still owed by the block
	class lock_scoreboard;
		logic [TKT_BITS-1:0] tickets [NUM_REQ];
		btl_pkg::btl_result_t owed_q[$];
		int unsigned mismatches, results_seen;
		int unsigned takes, polls, grants, overflows, empty_polls, releases, odd_ops;

		function void clear();
			foreach (tickets[i])
				tickets[i] = '0;
			owed_q.delete();
		endfunction

		function logic [TKT_BITS-1:0] highest();
			logic [TKT_BITS-1:0] top;
			top = '0;
			foreach (tickets[j])
				if (tickets[j] > top)
					top = tickets[j];
			return top;
		endfunction

		// lowest (ticket, requester) pair among nonzero tickets wins
		function bit wins(int who);
			logic [TKT_BITS-1:0] mine;
			mine = tickets[who];
			if (mine == '0)
				return 1'b0;
			foreach (tickets[j]) begin
				if (j != who && tickets[j] != '0 &&
						(tickets[j] < mine || (tickets[j] == mine && j < who)))
					return 1'b0;
			end
			return 1'b1;
		endfunction

		function void note(btl_pkg::btl_cmd_t c);
			btl_pkg::btl_result_t outcome;
			logic [TKT_BITS:0] next_ticket;
			logic [TKT_BITS-1:0] held;
			int who;
			outcome = '0;
			held = '0;
			who = int'(c.requester);
			if (who >= NUM_REQ) begin
				// table untouched for requesters the block does not have
				if (c.op == btl_pkg::OP_POLL)
					outcome.status = btl_pkg::ST_NO_TICKET;
			end else begin
				case (c.op)
				btl_pkg::OP_TAKE: begin
					takes++;
					next_ticket = {1'b0, highest()} + 1'b1;
					if (next_ticket[TKT_BITS]) begin
						outcome.status = btl_pkg::ST_OVERFLOW;
						overflows++;
					end else begin
						tickets[who] = next_ticket[TKT_BITS-1:0];
					end
					held = tickets[who];
				end
				btl_pkg::OP_POLL: begin
					polls++;
					held = tickets[who];
					if (held == '0) begin
						outcome.status = btl_pkg::ST_NO_TICKET;
						empty_polls++;
					end else begin
						outcome.granted = wins(who);
						if (outcome.granted)
							grants++;
					end
				end
				btl_pkg::OP_RELEASE: begin
					releases++;
					tickets[who] = '0;
				end
				default: begin
					odd_ops++;
					held = tickets[who];
				end
				endcase
			end
			outcome.ticket_value = held[btl_pkg::OUT_TICKET_BITS-1:0];
			owed_q.push_back(outcome);
		endfunction

		function void check(btl_pkg::btl_result_t got);
			btl_pkg::btl_result_t want;
			if (owed_q.size() == 0) begin
				$error("result with nothing outstanding: ticket_value %0d granted %0d status %0d",
					got.ticket_value, got.granted, got.status);
				mismatches++;
				return;
			end
			want = owed_q.pop_front();
			results_seen++;
			if (got.ticket_value !== want.ticket_value) begin
				$error("ticket_value: expected %0d, got %0d", want.ticket_value, got.ticket_value);
				mismatches++;
			end
			if (got.granted !== want.granted) begin
				$error("granted: expected %0d, got %0d", want.granted, got.granted);
				mismatches++;
			end
			if (got.status !== want.status) begin
				$error("status: expected %0d, got %0d", want.status, got.status);
				mismatches++;
			end
		endfunction
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 start;
	btl_pkg::btl_cmd_t    cmd;
	logic                 busy;
	logic                 done;
	btl_pkg::btl_result_t result;

	lock_scoreboard sb;
	int unsigned items_sent;
	int unsigned stall_cycles;

	bakery_ticket_lock_core #(
		.NUM_REQUESTERS(NUM_REQ),
		.TICKET_BITS   (TKT_BITS)
	) uut (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.cmd   (cmd),
		.busy  (busy),
		.done  (done),
		.result(result)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	function automatic btl_pkg::btl_cmd_t make_cmd(logic [btl_pkg::OP_BITS-1:0] op, int who);
		btl_pkg::btl_cmd_t c;
		c.op = op;
		c.requester = who[btl_pkg::REQ_BITS-1:0];
		return c;
	endfunction

	function automatic btl_pkg::btl_cmd_t any_cmd();
		int unsigned r;
		r = $urandom;
		return make_cmd(r[btl_pkg::OP_BITS-1:0],
			int'($urandom_range(0, 2**btl_pkg::REQ_BITS - 1)));
	endfunction

	// what a well-behaved requester would do next, given its ticket
	function automatic btl_pkg::btl_cmd_t lock_step(int who);
		int roll;
		roll = $urandom_range(0, 99);
		if (sb.tickets[who] == '0)
			return make_cmd(btl_pkg::OP_TAKE, who);
		if (sb.wins(who))
			return make_cmd(roll < 80 ? btl_pkg::OP_RELEASE : btl_pkg::OP_POLL, who);
		if (roll < 70)
			return make_cmd(btl_pkg::OP_POLL, who);
		if (roll < 85)
			return make_cmd(btl_pkg::OP_TAKE, who);
		return make_cmd(btl_pkg::OP_RELEASE, who);
	endfunction

	// one item: start low with junk on cmd while the block is busy and during
	// random idle cycles once it is free, then start held until it is taken
	task automatic drive_item(btl_pkg::btl_cmd_t c);
		@(negedge clk);
		while (busy) begin
			start <= 1'b0;
			cmd <= any_cmd();
			@(negedge clk);
		end
		while (!(items_sent >= 700 && items_sent < 1000) && $urandom_range(0, 99) < 28) begin
			start <= 1'b0;
			cmd <= any_cmd();
			@(negedge clk);
		end
		start <= 1'b1;
		cmd <= c;
		do
			@(posedge clk);
		while (busy);
		sb.note(c);
		items_sent++;
	endtask

	// push the largest ticket to the top, then bump into the overflow refusal
	task automatic climb();
		while (sb.highest() != TICKET_TOP)
			drive_item(make_cmd(btl_pkg::OP_TAKE, $urandom_range(0, NUM_REQ - 1)));
		repeat ($urandom_range(1, 4))
			drive_item(make_cmd(btl_pkg::OP_TAKE, $urandom_range(0, NUM_REQ - 1)));
	endtask

	// everyone lets go, so tickets restart from one
	task automatic drain();
		for (int r = 0; r < NUM_REQ; r++)
			if (sb.tickets[r] != '0)
				drive_item(make_cmd(btl_pkg::OP_RELEASE, r));
	endtask

	// results are captured on the done cycle; no backpressure exists
	always @(posedge clk) begin
		if (arst_n) begin
			if (done)
				sb.check(result);
			if ((start && !busy) || done)
				stall_cycles = 0;
			else
				stall_cycles++;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("timeout: no progress for %0d cycles", STALL_LIMIT);
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	initial begin
		int kind;
		sb = new();
		sb.clear();
		items_sent = 0;
		stall_cycles = 0;
		arst_n = 1'b0;
		start = 1'b0;
		cmd = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: empty table, retake, grant order, release, unused op
		drive_item(make_cmd(btl_pkg::OP_POLL, 0));
		drive_item(make_cmd(btl_pkg::OP_RELEASE, 5));
		drive_item(make_cmd(btl_pkg::OP_UNUSED, 3));
		drive_item(make_cmd(btl_pkg::OP_TAKE, NUM_REQ - 1));
		drive_item(make_cmd(btl_pkg::OP_TAKE, 0));
		drive_item(make_cmd(btl_pkg::OP_TAKE, 0));
		drive_item(make_cmd(btl_pkg::OP_POLL, NUM_REQ - 1));
		drive_item(make_cmd(btl_pkg::OP_POLL, 0));
		drive_item(make_cmd(btl_pkg::OP_UNUSED, 0));
		drive_item(make_cmd(btl_pkg::OP_TAKE, 7));
		drive_item(make_cmd(btl_pkg::OP_RELEASE, NUM_REQ - 1));
		drive_item(make_cmd(btl_pkg::OP_POLL, 0));
		drive_item(make_cmd(btl_pkg::OP_POLL, 7));
		drive_item(make_cmd(btl_pkg::OP_RELEASE, 0));
		drive_item(make_cmd(btl_pkg::OP_POLL, 7));
		drive_item(make_cmd(btl_pkg::OP_RELEASE, 7));
		drive_item(make_cmd(btl_pkg::OP_RELEASE, 7));
		drive_item(make_cmd(btl_pkg::OP_POLL, NUM_REQ - 1));
		drive_item(make_cmd(btl_pkg::OP_UNUSED, NUM_REQ - 1));

		// overflow reached early, then mixed episodes
		climb();
		drain();
		while (items_sent < ITEM_TARGET) begin
			kind = $urandom_range(0, 99);
			if (kind < 6) begin
				drain();
			end else if (kind < 10) begin
				climb();
			end else begin
				repeat (20) begin
					if ($urandom_range(0, 99) < 75)
						drive_item(lock_step($urandom_range(0, NUM_REQ - 1)));
					else
						drive_item(any_cmd());
				end
			end
		end

		@(negedge clk);
		start <= 1'b0;
		while (sb.owed_q.size() != 0)
			@(posedge clk);
		repeat (3 * (NUM_REQ + 3)) @(posedge clk);

		$display("%0d items, %0d results: %0d takes (%0d refused on overflow), %0d polls",
			items_sent, sb.results_seen, sb.takes, sb.overflows, sb.polls);
		$display("%0d grants, %0d polls without ticket, %0d releases, %0d unused-op items",
			sb.grants, sb.empty_polls, sb.releases, sb.odd_ops);
		if (sb.mismatches == 0 && sb.owed_q.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
